/* rtl/core/bmw_pkg.sv */
// ----------------------------------------------------------------------------
// Block map walker package
// Shared types, codes and geometry helpers for the ext2 block map walker.
// ----------------------------------------------------------------------------
package bmw_pkg;

  // Fixed layout of the inode pointer slots.
  localparam int unsigned DIRECT_SLOTS = 12;
  localparam int unsigned NUM_SLOTS    = 15;
  localparam logic [3:0]  SLOT_SINGLE  = 4'd12;
  localparam logic [3:0]  SLOT_DOUBLE  = 4'd13;
  localparam logic [3:0]  SLOT_TRIPLE  = 4'd14;

  // Default depth of the command queue between front and back.
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // Request type codes on the input channel.
  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_MAP  = 2'd1;
  localparam logic [1:0] REQ_RESP = 2'd2;

  // Result kind codes.
  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_FINAL = 1'b1;

  // Classified command kinds held in the queue.
  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_MAP,
    CMD_RESP
  } cmd_kind_t;

  // One classified command.
  typedef struct packed {
    cmd_kind_t   kind;
    logic [3:0]  slot;    // slot to write (load) or to read (map)
    logic [31:0] data;    // load value or returned word
    logic        ok;      // read status of a response
    logic        zero;    // map is out of range, answer is 0
    logic [1:0]  levels;  // pointer words to read, 0 for a direct map
    logic [9:0]  word;    // word index of the first read
    logic [9:0]  second;  // word index of the next level
    logic [9:0]  third;   // word index of the level after that
  } cmd_t;

  // Geometry that follows from the block size setting.
  typedef struct packed {
    logic [3:0]  sh;     // log2 of pointers per block
    logic [31:0] base2;  // first logical block of the double range
    logic [31:0] base3;  // first logical block of the triple range
    logic [31:0] lim3;   // size of the triple range
  } geom_t;

  function automatic geom_t bmw_geom(input logic [1:0] bsl);
    geom_t g;
    unique case (bsl)
      2'd0: begin
        g.sh    = 4'd8;
        g.base2 = 32'(DIRECT_SLOTS + (1 << 8));
        g.base3 = 32'(DIRECT_SLOTS + (1 << 8) + (1 << 16));
        g.lim3  = 32'(1 << 24);
      end
      2'd1: begin
        g.sh    = 4'd9;
        g.base2 = 32'(DIRECT_SLOTS + (1 << 9));
        g.base3 = 32'(DIRECT_SLOTS + (1 << 9) + (1 << 18));
        g.lim3  = 32'(1 << 27);
      end
      default: begin
        // Settings two and three both mean 1024 pointers per block.
        g.sh    = 4'd10;
        g.base2 = 32'(DIRECT_SLOTS + (1 << 10));
        g.base3 = 32'(DIRECT_SLOTS + (1 << 10) + (1 << 20));
        g.lim3  = 32'(1 << 30);
      end
    endcase
    return g;
  endfunction

endpackage

/* rtl/core/bmw_front.sv */
// ----------------------------------------------------------------------------
// Block map walker front end
// Holds the block size register, decodes input items and splits a logical
// block index into its pointer range and word indices.
// ----------------------------------------------------------------------------
module bmw_front
  import bmw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic [1:0]  cfg_data,
  input  logic        push,
  input  logic        full,
  input  logic [1:0]  in_req_type,
  input  logic [3:0]  in_slot,
  input  logic [31:0] in_pointer_value,
  input  logic [31:0] in_logical_block,
  input  logic [31:0] in_mem_word,
  input  logic        in_mem_ok,
  output logic        enq_valid,
  output cmd_t        enq_cmd
);

  logic [1:0]  block_size_log_r;
  logic [1:0]  block_size_log_nxt;
  geom_t       geom;
  logic [9:0]  mask;
  logic [4:0]  sh2;
  logic [31:0] idx;
  logic [31:0] i1;
  logic [31:0] i2;
  logic [31:0] i3;
  logic [31:0] i2_hi;
  logic [31:0] i3_mid;
  logic [31:0] i3_hi;
  logic        in_direct;
  logic        in_single;
  logic        in_double;
  logic        in_triple;

  // Block size register, written by every configuration transfer.
  always_comb begin
    block_size_log_nxt = cfg_valid ? cfg_data : block_size_log_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_size_log_r <= 2'd0;
    end else begin
      block_size_log_r <= block_size_log_nxt;
    end
  end

  // Range offsets, computed in parallel against fixed bases.
  always_comb begin
    geom   = bmw_geom(block_size_log_r);
    mask   = 10'((11'd1 << geom.sh) - 11'd1);
    sh2    = {geom.sh, 1'b0};
    idx    = in_logical_block;
    i1     = idx - 32'(DIRECT_SLOTS);
    i2     = idx - geom.base2;
    i3     = idx - geom.base3;
    i2_hi  = i2 >> geom.sh;
    i3_mid = i3 >> geom.sh;
    i3_hi  = i3 >> sh2;

    in_direct = idx < 32'(DIRECT_SLOTS);
    in_single = !in_direct && (idx < geom.base2);
    in_double = (idx >= geom.base2) && (idx < geom.base3);
    in_triple = (idx >= geom.base3) && (i3 < geom.lim3);
  end

  // Build the queued command.
  always_comb begin
    enq_cmd        = '0;
    enq_cmd.kind   = CMD_LOAD;
    enq_cmd.data   = in_pointer_value;
    enq_cmd.slot   = in_slot;
    enq_valid      = 1'b0;
    unique case (in_req_type)
      REQ_LOAD: begin
        // A load to a slot that does not exist is dropped here.
        enq_valid = push && !full && (in_slot < 4'(NUM_SLOTS));
      end
      REQ_MAP: begin
        enq_valid    = push && !full;
        enq_cmd.kind = CMD_MAP;
        priority if (in_direct) begin
          enq_cmd.slot = idx[3:0];
        end else if (in_single) begin
          enq_cmd.slot   = SLOT_SINGLE;
          enq_cmd.levels = 2'd1;
          enq_cmd.word   = i1[9:0];
        end else if (in_double) begin
          enq_cmd.slot   = SLOT_DOUBLE;
          enq_cmd.levels = 2'd2;
          enq_cmd.word   = i2_hi[9:0];
          enq_cmd.second = i2[9:0] & mask;
        end else if (in_triple) begin
          enq_cmd.slot   = SLOT_TRIPLE;
          enq_cmd.levels = 2'd3;
          enq_cmd.word   = i3_hi[9:0];
          enq_cmd.second = i3_mid[9:0] & mask;
          enq_cmd.third  = i3[9:0] & mask;
        end else begin
          enq_cmd.zero = 1'b1;
        end
      end
      REQ_RESP: begin
        enq_valid    = push && !full;
        enq_cmd.kind = CMD_RESP;
        enq_cmd.data = in_mem_word;
        enq_cmd.ok   = in_mem_ok;
      end
      default: begin
        // Unused request type: no command.
        enq_valid = 1'b0;
      end
    endcase
  end

endmodule

/* rtl/core/bmw_cmd_queue.sv */
// ----------------------------------------------------------------------------
// Block map walker command queue
// Small first-in first-out buffer of classified commands between the front
// end and the back end.
// ----------------------------------------------------------------------------
module bmw_cmd_queue
  import bmw_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  cmd_t wr_cmd,
  input  logic rd_en,
  output cmd_t rd_cmd,
  output logic q_full,
  output logic q_empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r;
  logic [PW-1:0] rd_ptr_nxt;
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      count_nxt = count_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_cmd;
    end
  end

  assign rd_cmd  = mem_r[rd_ptr_r];
  assign q_full  = (count_r == CW'(DEPTH));
  assign q_empty = (count_r == '0);

`ifndef ASSERT_OFF
  a_no_read_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> count_r != '0)
    else $error("command queue read while empty");

  a_no_write_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> count_r != CW'(DEPTH))
    else $error("command queue written while full");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("command queue fill count out of range");
`endif

endmodule

/* rtl/core/bmw_back.sv */
// ----------------------------------------------------------------------------
// Block map walker back end
// Holds the inode pointer slots and the walk state, carries out queued
// commands in order and keeps the output register.
// ----------------------------------------------------------------------------
module bmw_back
  import bmw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        head_valid,
  input  cmd_t        head,
  output logic        head_take,
  input  logic        pop,
  output logic        empty,
  output logic        out_kind,
  output logic [31:0] out_read_block,
  output logic [9:0]  out_read_word_index,
  output logic [31:0] out_physical_block
);

  logic [31:0] ptr_r [NUM_SLOTS];
  logic [1:0]  levels_r;
  logic [1:0]  levels_nxt;
  logic [9:0]  second_r;
  logic [9:0]  second_nxt;
  logic [9:0]  third_r;
  logic [9:0]  third_nxt;
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic        kind_r;
  logic [31:0] blk_r;
  logic [9:0]  word_r;
  logic [31:0] phys_r;

  logic [31:0] ptr_rd;
  logic        produce;
  logic        ptr_we;
  logic        out_free;
  logic        res_kind;
  logic [31:0] res_blk;
  logic [9:0]  res_word;
  logic [31:0] res_phys;
  logic [1:0]  cand_levels;
  logic [9:0]  cand_second;
  logic [9:0]  cand_third;

  assign ptr_rd = ptr_r[head.slot];

  // Execute the command at the head of the queue.
  always_comb begin
    produce     = 1'b0;
    ptr_we      = 1'b0;
    res_kind    = KIND_FINAL;
    res_blk     = '0;
    res_word    = '0;
    res_phys    = '0;
    cand_levels = levels_r;
    cand_second = second_r;
    cand_third  = third_r;
    unique case (head.kind)
      CMD_LOAD: begin
        ptr_we = 1'b1;
      end
      CMD_MAP: begin
        // A new map always abandons any walk in progress.
        produce     = 1'b1;
        cand_levels = 2'd0;
        if (!head.zero) begin
          if (head.levels == 2'd0) begin
            res_phys = ptr_rd;
          end else if (ptr_rd != '0) begin
            res_kind    = KIND_READ;
            res_blk     = ptr_rd;
            res_word    = head.word;
            cand_levels = head.levels;
            cand_second = head.second;
            cand_third  = head.third;
          end
        end
      end
      CMD_RESP: begin
        // A response with no walk in progress is dropped.
        if (levels_r != 2'd0) begin
          produce     = 1'b1;
          cand_levels = 2'd0;
          if (head.ok) begin
            if (levels_r == 2'd1) begin
              res_phys = head.data;
            end else if (head.data != '0) begin
              res_kind    = KIND_READ;
              res_blk     = head.data;
              res_word    = second_r;
              cand_levels = levels_r - 2'd1;
              cand_second = third_r;
              cand_third  = '0;
            end
          end
        end
      end
      default: begin
        produce = 1'b0;
      end
    endcase
  end

  // A command leaves the queue once its result has a place to go.
  assign out_free  = !out_valid_r || pop;
  assign head_take = head_valid && (!produce || out_free);

  always_comb begin
    levels_nxt    = head_take ? cand_levels : levels_r;
    second_nxt    = head_take ? cand_second : second_r;
    third_nxt     = head_take ? cand_third : third_r;
    out_valid_nxt = (head_take && produce) ? 1'b1 : (pop ? 1'b0 : out_valid_r);
  end

  // Walk state and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      levels_r    <= 2'd0;
      second_r    <= '0;
      third_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      levels_r    <= levels_nxt;
      second_r    <= second_nxt;
      third_r     <= third_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Inode pointer slots, all zero after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        ptr_r[i] <= '0;
      end
    end else if (head_take && ptr_we) begin
      ptr_r[head.slot] <= head.data;
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (head_take && produce) begin
      kind_r <= res_kind;
      blk_r  <= res_blk;
      word_r <= res_word;
      phys_r <= res_phys;
    end
  end

  assign empty               = !out_valid_r;
  assign out_kind            = kind_r;
  assign out_read_block      = blk_r;
  assign out_read_word_index = word_r;
  assign out_physical_block  = phys_r;

`ifndef ASSERT_OFF
  a_read_keeps_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (head_take && produce && res_kind == KIND_READ) |=> levels_r != 2'd0)
    else $error("read request issued without a walk in progress");

  a_final_ends_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (head_take && produce && res_kind == KIND_FINAL) |=> levels_r == 2'd0)
    else $error("final mapping left a walk in progress");
`endif

endmodule

/* rtl/core/ext2_block_map_walker.sv */
// ----------------------------------------------------------------------------
// ext2 block map walker
// Top level: front end, command queue and back end of the walker.
// ----------------------------------------------------------------------------
// Translates a file's logical block index into a physical block number over
// the ext2 layout of twelve direct pointers and single, double and triple
// indirect pointers. Load items fill the fifteen inode pointer slots; a map
// item returns a final mapping or a read request for one pointer word, and
// each response item to a walk in progress moves the walk one level down. A
// transfer on the input is classified in the same cycle and written to a
// command queue of QUEUE_DEPTH entries; the back end executes one command per
// cycle from the queue head into the output register, so a result passes the
// queue entry and then the output register before it is on the output ports.
// With pop kept high the block sustains one item per cycle; the throughput
// limit is the single execute step of the back end, which stalls only while
// the output register holds an untaken result.
// The block size register may be written only while the block is idle.
// ----------------------------------------------------------------------------
module ext2_block_map_walker
  import bmw_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_req_type,
  input  logic [3:0]  in_slot,
  input  logic [31:0] in_pointer_value,
  input  logic [31:0] in_logical_block,
  input  logic [31:0] in_mem_word,
  input  logic        in_mem_ok,
  output logic        empty,
  input  logic        pop,
  output logic        out_kind,
  output logic [31:0] out_read_block,
  output logic [9:0]  out_read_word_index,
  output logic [31:0] out_physical_block
);

  logic enq_valid;
  cmd_t enq_cmd;
  cmd_t head;
  logic head_take;
  logic q_empty;

  // The block size register takes every configuration transfer at once.
  assign cfg_ready = 1'b1;

  bmw_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_data         (cfg_data),
    .push             (push),
    .full             (full),
    .in_req_type      (in_req_type),
    .in_slot          (in_slot),
    .in_pointer_value (in_pointer_value),
    .in_logical_block (in_logical_block),
    .in_mem_word      (in_mem_word),
    .in_mem_ok        (in_mem_ok),
    .enq_valid        (enq_valid),
    .enq_cmd          (enq_cmd)
  );

  bmw_cmd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (enq_valid),
    .wr_cmd  (enq_cmd),
    .rd_en   (head_take),
    .rd_cmd  (head),
    .q_full  (full),
    .q_empty (q_empty)
  );

  bmw_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .head_valid          (!q_empty),
    .head                (head),
    .head_take           (head_take),
    .pop                 (pop),
    .empty               (empty),
    .out_kind            (out_kind),
    .out_read_block      (out_read_block),
    .out_read_word_index (out_read_word_index),
    .out_physical_block  (out_physical_block)
  );

endmodule
